### hw/rtl/stq_pkg.sv
// stq_pkg: shared types and constants of the sorted timer queue
// no dependencies; used by the cell and the top level
package stq_pkg;

    localparam int NUM_SLOTS = 16;
    localparam int SLOT_W    = 4;

    typedef enum logic [1:0] {
        OP_ARM    = 2'd0,
        OP_CANCEL = 2'd1,
        OP_TICK   = 2'd2,
        OP_SEARCH = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_ACK    = 2'd0,
        KIND_FIRED  = 2'd1,
        KIND_TICK   = 2'd2,
        KIND_SEARCH = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REMOVE,
        ST_INSERT,
        ST_EMIT,
        ST_CHECK,
        ST_FEMIT
    } state_t;

    typedef enum logic [1:0] {
        MODE_HOLD,
        MODE_REMOVE,
        MODE_INSERT,
        MODE_SEARCH
    } mode_t;

    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] slot;
        logic [31:0]       deadline;
        logic [23:0]       period;
        logic [7:0]        code;
        logic [3:0]        owner;
        logic [15:0]       tag;
        logic              periodic;
    } entry_t;

    typedef struct packed {
        mode_t             mode;
        logic [SLOT_W-1:0] slot;
        logic [31:0]       key;
        logic [31:0]       now;
        entry_t            ent;
        logic [7:0]        code;
        logic [3:0]        owner;
        logic [15:0]       tag;
    } cell_ctrl_t;

    typedef struct packed {
        logic              shift;
        logic              found;
        logic [SLOT_W-1:0] slot;
    } chain_t;

    // time to deadline, zero once due, saturated to 24 bits
    function automatic logic [23:0] remaining(input logic [31:0] diff);
        logic [23:0] r;
        if (diff[31])
            r = '0;
        else if (|diff[30:24])
            r = '1;
        else
            r = diff[23:0];
        return r;
    endfunction

endpackage

### hw/rtl/stq_in_if.sv
// stq_in_if: command channel of the sorted timer queue
// no dependencies
interface stq_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [3:0]  slot;
    logic [3:0]  owner;
    logic [7:0]  code;
    logic [15:0] tag;
    logic [23:0] duration_ms;
    logic        periodic;

    modport source (output valid, operation, slot, owner, code, tag, duration_ms, periodic,
                    input ready);
    modport sink (input valid, operation, slot, owner, code, tag, duration_ms, periodic,
                  output ready);
endinterface

### hw/rtl/stq_out_if.sv
// stq_out_if: result channel of the sorted timer queue
// no dependencies
interface stq_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [3:0]  slot_res;
    logic [3:0]  owner_res;
    logic [7:0]  code_res;
    logic [15:0] tag_res;
    logic        found;
    logic        queue_empty;
    logic [23:0] remaining_ms;
    logic        last;

    modport source (output valid, kind, slot_res, owner_res, code_res, tag_res, found,
                    queue_empty, remaining_ms, last, input ready);
    modport sink (input valid, kind, slot_res, owner_res, code_res, tag_res, found,
                  queue_empty, remaining_ms, last, output ready);
endinterface

### hw/rtl/stq_cell.sv
// stq_cell: one position of the deadline-ordered timer chain
// depends on stq_pkg; instanced in a row by sorted_timer_queue
module stq_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  stq_pkg::cell_ctrl_t ctrl,
    input  stq_pkg::entry_t     left,
    input  stq_pkg::entry_t     right,
    input  stq_pkg::chain_t     cin,
    output stq_pkg::chain_t     cout,
    output stq_pkg::entry_t     ent
);

    stq_pkg::entry_t ent_reg;
    stq_pkg::entry_t ent_next;
    logic [31:0]     ent_dist;
    logic            gt;
    logic            hit;

    assign ent      = ent_reg;
    assign ent_dist = ent_reg.deadline - ctrl.now;

    always_comb
    begin
        ent_next = ent_reg;
        cout     = cin;
        gt       = !(ent_reg.valid && (ent_dist <= ctrl.key));
        hit      = 1'b0;
        case (ctrl.mode)
            stq_pkg::MODE_REMOVE:
            begin
                hit        = ent_reg.valid && (ent_reg.slot == ctrl.slot);
                cout.shift = cin.shift | hit;
                if (cout.shift)
                    ent_next = right;
            end
            stq_pkg::MODE_INSERT:
            begin
                // entries with equal distance stay ahead of the new one
                cout.shift = cin.shift | gt;
                if (cin.shift)
                    ent_next = left;
                else if (gt)
                    ent_next = ctrl.ent;
            end
            stq_pkg::MODE_SEARCH:
            begin
                hit = ent_reg.valid && (ent_reg.code == ctrl.code) &&
                      (ent_reg.owner == ctrl.owner) && (ent_reg.tag == ctrl.tag);
                if (!cin.found && hit)
                begin
                    cout.found = 1'b1;
                    cout.slot  = ent_reg.slot;
                end
            end
            default:
            begin
                ent_next = ent_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ent_reg <= '0;
        else
            ent_reg <= ent_next;
    end

endmodule

### hw/rtl/sorted_timer_queue.sv
// sorted_timer_queue: top level, command sequencer over a chain of timer cells
// depends on stq_pkg, stq_in_if, stq_out_if and stq_cell
//
// Timers sit in a row of NUM_SLOTS cells kept in deadline order, the head
// in cell 0. Each command is handled one at a time: search and an out of
// range arm or cancel go straight to the result, cancel first pulls the old
// entry out of the chain, arm pulls the old entry out and then shifts the new
// entry in. A tick with nothing due answers from its check; each timer that a
// tick fires is pulled out, put back if periodic, and reported before the next
// check. Every result step waits while the result channel is not ready.
// A new command is taken while the previous result still waits at the output.
module sorted_timer_queue (
    input logic      clk,
    input logic      rst_n,
    stq_in_if.sink   in_ch,
    stq_out_if.source out_ch
);

    typedef struct packed {
        stq_pkg::kind_t kind;
        logic [3:0]     slot_res;
        logic [3:0]     owner_res;
        logic [7:0]     code_res;
        logic [15:0]    tag_res;
        logic           found;
        logic           queue_empty;
        logic [23:0]    remaining_ms;
        logic           last;
    } out_t;

    typedef struct packed {
        stq_pkg::op_t op;
        logic [3:0]   slot;
        logic [3:0]   owner;
        logic [7:0]   code;
        logic [15:0]  tag;
    } cmd_t;

    stq_pkg::state_t state_reg, state_next;
    cmd_t            cmd_reg, cmd_next;
    stq_pkg::entry_t ins_reg, ins_next;
    stq_pkg::entry_t fire_reg, fire_next;
    logic [31:0]     now_reg, now_next;
    out_t            out_reg, out_next;
    logic            out_valid_reg, out_valid_next;

    stq_pkg::cell_ctrl_t ctrl;
    stq_pkg::entry_t     ents [stq_pkg::NUM_SLOTS];
    stq_pkg::chain_t     chain [stq_pkg::NUM_SLOTS+1];
    logic [stq_pkg::NUM_SLOTS-1:0] valid_vec;

    stq_pkg::entry_t head;
    logic [31:0]     head_dist;
    logic            head_due;
    logic            out_free;
    logic [31:0]     tick_now;
    logic [23:0]     reperiod;

    assign chain[0] = '0;

    for (genvar i = 0; i < stq_pkg::NUM_SLOTS; i++)
    begin : g_cell
        stq_pkg::entry_t left_ent;
        stq_pkg::entry_t right_ent;
        if (i == 0)
            assign left_ent = '0;
        else
            assign left_ent = ents[i-1];
        if (i == stq_pkg::NUM_SLOTS - 1)
            assign right_ent = '0;
        else
            assign right_ent = ents[i+1];

        stq_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (ctrl),
            .left  (left_ent),
            .right (right_ent),
            .cin   (chain[i]),
            .cout  (chain[i+1]),
            .ent   (ents[i])
        );
        assign valid_vec[i] = ents[i].valid;
    end

    assign head      = ents[0];
    assign head_dist = head.deadline - now_reg;
    assign head_due  = head.valid && (head_dist <= 32'd1);
    assign out_free  = !out_valid_reg || out_ch.ready;
    assign tick_now  = now_reg + 32'd1;
    assign reperiod  = (head.period == '0) ? 24'd1 : head.period;

    assign in_ch.ready = (state_reg == stq_pkg::ST_IDLE);

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.kind         = out_reg.kind;
    assign out_ch.slot_res     = out_reg.slot_res;
    assign out_ch.owner_res    = out_reg.owner_res;
    assign out_ch.code_res     = out_reg.code_res;
    assign out_ch.tag_res      = out_reg.tag_res;
    assign out_ch.found        = out_reg.found;
    assign out_ch.queue_empty  = out_reg.queue_empty;
    assign out_ch.remaining_ms = out_reg.remaining_ms;
    assign out_ch.last         = out_reg.last;

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        ins_next       = ins_reg;
        fire_next      = fire_reg;
        now_next       = now_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;

        ctrl       = '0;
        ctrl.mode  = stq_pkg::MODE_HOLD;
        ctrl.now   = now_reg;
        ctrl.slot  = cmd_reg.slot;
        ctrl.ent   = ins_reg;
        ctrl.key   = ins_reg.deadline - now_reg;
        ctrl.code  = cmd_reg.code;
        ctrl.owner = cmd_reg.owner;
        ctrl.tag   = cmd_reg.tag;

        unique case (state_reg)
            stq_pkg::ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    cmd_next.op    = stq_pkg::op_t'(in_ch.operation);
                    cmd_next.slot  = in_ch.slot;
                    cmd_next.owner = in_ch.owner;
                    cmd_next.code  = in_ch.code;
                    cmd_next.tag   = in_ch.tag;
                    ins_next.valid    = 1'b1;
                    ins_next.slot     = in_ch.slot;
                    ins_next.deadline = now_reg + {8'd0, in_ch.duration_ms};
                    ins_next.period   = in_ch.duration_ms;
                    ins_next.code     = in_ch.code;
                    ins_next.owner    = in_ch.owner;
                    ins_next.tag      = in_ch.tag;
                    ins_next.periodic = in_ch.periodic;
                    unique case (stq_pkg::op_t'(in_ch.operation))
                        stq_pkg::OP_ARM, stq_pkg::OP_CANCEL:
                            state_next = (32'(in_ch.slot) < stq_pkg::NUM_SLOTS) ?
                                         stq_pkg::ST_REMOVE : stq_pkg::ST_EMIT;
                        stq_pkg::OP_TICK:
                            state_next = stq_pkg::ST_CHECK;
                        default:
                            state_next = stq_pkg::ST_EMIT;
                    endcase
                end
            end
            stq_pkg::ST_REMOVE:
            begin
                ctrl.mode  = stq_pkg::MODE_REMOVE;
                state_next = (cmd_reg.op == stq_pkg::OP_ARM) ?
                             stq_pkg::ST_INSERT : stq_pkg::ST_EMIT;
            end
            stq_pkg::ST_INSERT:
            begin
                ctrl.mode  = stq_pkg::MODE_INSERT;
                state_next = (cmd_reg.op == stq_pkg::OP_TICK) ?
                             stq_pkg::ST_FEMIT : stq_pkg::ST_EMIT;
            end
            stq_pkg::ST_EMIT:
            begin
                ctrl.mode = stq_pkg::MODE_SEARCH;
                if (out_free)
                begin
                    out_valid_next       = 1'b1;
                    out_next             = '0;
                    out_next.last        = 1'b1;
                    out_next.queue_empty = !head.valid;
                    out_next.remaining_ms = head.valid ?
                        stq_pkg::remaining(head.deadline - now_reg) : 24'd0;
                    if (cmd_reg.op == stq_pkg::OP_SEARCH)
                    begin
                        out_next.kind = stq_pkg::KIND_SEARCH;
                        if (chain[stq_pkg::NUM_SLOTS].found)
                        begin
                            // a hit carries exactly the fields searched for
                            out_next.found     = 1'b1;
                            out_next.slot_res  = chain[stq_pkg::NUM_SLOTS].slot;
                            out_next.owner_res = cmd_reg.owner;
                            out_next.code_res  = cmd_reg.code;
                            out_next.tag_res   = cmd_reg.tag;
                        end
                    end
                    else
                    begin
                        out_next.kind     = stq_pkg::KIND_ACK;
                        out_next.slot_res = cmd_reg.slot;
                    end
                    state_next = stq_pkg::ST_IDLE;
                end
            end
            stq_pkg::ST_CHECK:
            begin
                if (head_due)
                begin
                    ctrl.mode         = stq_pkg::MODE_REMOVE;
                    ctrl.slot         = head.slot;
                    fire_next         = head;
                    ins_next          = head;
                    ins_next.deadline = tick_now + {8'd0, reperiod};
                    state_next        = head.periodic ? stq_pkg::ST_INSERT : stq_pkg::ST_FEMIT;
                end
                else if (out_free)
                begin
                    out_valid_next       = 1'b1;
                    out_next             = '0;
                    out_next.kind        = stq_pkg::KIND_TICK;
                    out_next.last        = 1'b1;
                    out_next.queue_empty = !head.valid;
                    out_next.remaining_ms = head.valid ?
                        stq_pkg::remaining(head.deadline - tick_now) : 24'd0;
                    now_next   = tick_now;
                    state_next = stq_pkg::ST_IDLE;
                end
            end
            stq_pkg::ST_FEMIT:
            begin
                if (out_free)
                begin
                    out_valid_next        = 1'b1;
                    out_next              = '0;
                    out_next.kind         = stq_pkg::KIND_FIRED;
                    out_next.slot_res     = fire_reg.slot;
                    out_next.owner_res    = fire_reg.owner;
                    out_next.code_res     = fire_reg.code;
                    out_next.tag_res      = fire_reg.tag;
                    out_next.last         = !head_due;
                    out_next.queue_empty  = !head.valid;
                    out_next.remaining_ms = head.valid ?
                        stq_pkg::remaining(head.deadline - tick_now) : 24'd0;
                    if (head_due)
                        state_next = stq_pkg::ST_CHECK;
                    else
                    begin
                        now_next   = tick_now;
                        state_next = stq_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = stq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= stq_pkg::ST_IDLE;
            now_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            now_reg       <= now_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        ins_reg  <= ins_next;
        fire_reg <= fire_next;
        out_reg  <= out_next;
    end

    // occupied cells always form an unbroken run from the head
    a_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_vec & (valid_vec + 1'b1)) == '0)
        else $error("gap in timer chain");

    a_tick_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.kind == stq_pkg::KIND_TICK |-> out_reg.last)
        else $error("idle tick result not marked last");

    a_found_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.found |-> out_reg.kind == stq_pkg::KIND_SEARCH)
        else $error("found set outside a search answer");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.queue_empty |-> out_reg.remaining_ms == '0)
        else $error("empty queue reports time left");

    a_now_step: assert property (@(posedge clk) disable iff (!rst_n)
        now_reg != $past(now_reg) |-> now_reg == $past(now_reg) + 32'd1)
        else $error("clock moved by more than one tick");

endmodule
